// File: src/sensor_condition_wait_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Sensor condition wait table: assertion macros
// Shared concurrent check forms for the wait table RTL.
// ----------------------------------------------------------------------------
`ifndef SENSOR_CONDITION_WAIT_TABLE_UNIT_DEFINES_SVH
`define SENSOR_CONDITION_WAIT_TABLE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCWT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scwt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SCWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scwt: next-cycle check failed");

`endif

// File: src/scwt_pkg.sv
// ----------------------------------------------------------------------------
// Sensor condition wait table package
// Beat types, status codes and shared constants.
// ----------------------------------------------------------------------------
package scwt_pkg;

  // Operation codes
  localparam logic OP_SUBSCRIBE = 1'b0;
  localparam logic OP_POLL      = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_STORED = 2'd0;
  localparam logic [1:0] STATUS_DUP    = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;
  localparam logic [1:0] STATUS_POLL   = 2'd3;

  // Release limit per poll
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic        operation;
    logic [3:0]  waiter_id;
    logic [31:0] sensor_mask;
    logic        expected_level;
    logic [31:0] sensor_word;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       released;
    logic [3:0] released_id;
    logic       last;
  } out_t;

  // One table entry as held in memory
  typedef struct packed {
    logic [3:0]  waiter;
    logic [31:0] mask;
    logic        level;
  } entry_t;

  // Compare unit results
  typedef struct packed {
    logic met;
    logic id_eq;
  } match_t;

endpackage

// File: src/scwt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scwt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/scwt_match.sv
// ----------------------------------------------------------------------------
// Wait table compare unit
// Evaluates one entry per cycle: sensor condition and waiter id match.
// ----------------------------------------------------------------------------
module scwt_match (
  input  scwt_pkg::entry_t entry_i,
  input  logic [31:0]      word_i,
  input  logic [3:0]       id_i,
  output scwt_pkg::match_t match_o
);
  import scwt_pkg::*;

  logic any_set;

  // Level 0 waits for all masked bits clear, level 1 for any set
  assign any_set       = |(word_i & entry_i.mask);
  assign match_o.met   = entry_i.level ? any_set : !any_set;
  assign match_o.id_eq = (entry_i.waiter == id_i);

endmodule

// File: src/scwt_ctrl.sv
// ----------------------------------------------------------------------------
// Wait table sequencer
// Walks the slots one per cycle for subscribe and poll, unless a poll release
// waits on a full output; holds valid bits.
module scwt_ctrl #(
  parameter int unsigned TABLE_SLOTS = 8,
  localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  scwt_pkg::in_t        in_data_i,
  input  logic                 out_free_i,
  output logic                 res_push_o,
  output scwt_pkg::out_t       res_o,
  output logic                 ram_we_o,
  output logic [IDX_W-1:0]     ram_waddr_o,
  output scwt_pkg::entry_t     ram_wdata_o,
  output logic [IDX_W-1:0]     ram_raddr_o,
  input  scwt_pkg::entry_t     ram_rdata_i
);
  import scwt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [TABLE_SLOTS-1:0] valid_q, valid_d;
  logic                   op_q, op_d;
  logic [3:0]             id_q, id_d;
  logic [31:0]            mask_q, mask_d;
  logic                   level_q, level_d;
  logic [31:0]            word_q, word_d;
  logic                   dup_q, dup_d;
  logic                   free_found_q, free_found_d;
  logic [IDX_W-1:0]       free_slot_q, free_slot_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [3:0]             pend_id_q, pend_id_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic                   ent_valid;
  logic                   hit;
  logic                   step_ok;
  match_t                 match;

  // Shared compare unit, one slot per cycle while the walk is not stalled
  scwt_match u_match (
    .entry_i (ram_rdata_i),
    .word_i  (word_q),
    .id_i    (id_q),
    .match_o (match)
  );

  assign ent_valid = valid_q[idx_q];
  assign hit       = (op_q == OP_POLL) && ent_valid && match.met && (cnt_q < CNT_MAX);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    valid_d      = valid_q;
    op_d         = op_q;
    id_d         = id_q;
    mask_d       = mask_q;
    level_d      = level_q;
    word_d       = word_q;
    dup_d        = dup_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    cnt_d        = cnt_q;
    step_ok      = 1'b1;
    res_push_o   = 1'b0;
    res_o        = '0;
    ram_we_o     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d         = in_data_i.operation;
          id_d         = in_data_i.waiter_id;
          mask_d       = in_data_i.sensor_mask;
          level_d      = in_data_i.expected_level;
          word_d       = in_data_i.sensor_word;
          idx_d        = '0;
          dup_d        = 1'b0;
          free_found_d = 1'b0;
          free_slot_d  = '0;
          pend_valid_d = 1'b0;
          pend_id_d    = '0;
          cnt_d        = '0;
          state_d      = ST_WALK;
        end
      end

      ST_WALK: begin
        if (op_q == OP_POLL) begin
          // A new release flushes the held one as a non-final beat
          if (hit && pend_valid_q) begin
            if (out_free_i) begin
              res_push_o        = 1'b1;
              res_o.status      = STATUS_POLL;
              res_o.released    = 1'b1;
              res_o.released_id = pend_id_q;
              res_o.last        = 1'b0;
            end else begin
              step_ok = 1'b0;
            end
          end
          if (step_ok && hit) begin
            pend_valid_d   = 1'b1;
            pend_id_d      = ram_rdata_i.waiter;
            cnt_d          = cnt_q + CNT_W'(1);
            valid_d[idx_q] = 1'b0;
          end
        end else begin
          // Duplicate check and lowest free slot
          if (ent_valid && match.id_eq) begin
            dup_d = 1'b1;
          end else if (!ent_valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_slot_d  = idx_q;
          end
        end
        if (step_ok) begin
          if (dup_d || (idx_q == LAST_IDX)) begin
            state_d = ST_FINISH;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end

      ST_FINISH: begin
        if (out_free_i) begin
          res_push_o = 1'b1;
          res_o.last = 1'b1;
          if (op_q == OP_POLL) begin
            res_o.status      = STATUS_POLL;
            res_o.released    = pend_valid_q;
            res_o.released_id = pend_id_q;
          end else if (dup_q) begin
            res_o.status = STATUS_DUP;
          end else if (free_found_q) begin
            res_o.status         = STATUS_STORED;
            ram_we_o             = 1'b1;
            valid_d[free_slot_q] = 1'b1;
          end else begin
            res_o.status = STATUS_FULL;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign ram_raddr_o = idx_d;
  assign ram_waddr_o = free_slot_q;
  assign ram_wdata_o = '{waiter: id_q, mask: mask_q, level: level_q};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      idx_q        <= '0;
      dup_q        <= 1'b0;
      free_found_q <= 1'b0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      idx_q        <= idx_d;
      dup_q        <= dup_d;
      free_found_q <= free_found_d;
      pend_valid_q <= pend_valid_d;
      cnt_q        <= cnt_d;
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    id_q        <= id_d;
    mask_q      <= mask_d;
    level_q     <= level_d;
    word_q      <= word_d;
    free_slot_q <= free_slot_d;
    pend_id_q   <= pend_id_d;
  end

endmodule

// File: src/sensor_condition_wait_table_unit.sv
// ----------------------------------------------------------------------------
// Sensor condition wait table unit
// Holds waiters on sensor bit conditions; releases them on poll beats.
//
//   Channel | Dir | Handshake               | Payload
//   --------+-----+-------------------------+----------------------------
//   in      | in  | in_valid_i / in_ready_o | in_data_i  (scwt_pkg::in_t)
//   out     | out | out_valid_o/out_ready_i | out_data_o (scwt_pkg::out_t)
//
// An item is accepted in the idle state; the sequencer then walks the slots one
// per cycle through the shared compare unit (entries read from the two-port
// table memory), then emits the final beat, and only then accepts the next item.
// A duplicate subscribe ends the walk at the matching slot.
// A beat that finds the output register full and not taken waits, and the walk holds.
// Reset clears all slot valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "sensor_condition_wait_table_unit_defines.svh"

module sensor_condition_wait_table_unit #(
  parameter int unsigned TABLE_SLOTS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  scwt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output scwt_pkg::out_t out_data_o
);
  import scwt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic             out_free;
  logic             res_push;
  out_t             res;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic             out_valid_q;
  out_t             out_q;
  logic             rel_beat;

  // Sequencer
  scwt_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_free_i  (out_free),
    .res_push_o  (res_push),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Entry table memory
  scwt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  assign rel_beat = res.released && (res.status == STATUS_POLL);

  `SCWT_ASSERT_NOW(a_push_into_free, clk_i, rst_ni, res_push, out_free)
  `SCWT_ASSERT_NOW(a_nonfinal_is_release, clk_i, rst_ni, res_push && !res.last, rel_beat)
  `SCWT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `SCWT_ASSERT_NEXT(a_idle_after_last, clk_i, rst_ni, res_push && res.last, in_ready_o)

endmodule
